@@ rtl/abr_pkg.sv @@
// shared constants, types and the arctangent table of the ray angle unit
package abr_pkg;

	localparam int COORD_BITS      = 16;
	localparam int CORDIC_STEPS    = 16;
	localparam int ANGLE_FRAC_BITS = 7;

	// internal angle format: degrees with ANG_Q fractional bits
	localparam int ANG_Q     = 16;
	localparam int ANGLE_W   = 16;
	localparam int TABLE_LEN = 24;

	localparam int DIFF_W = COORD_BITS + 1;
	// two guard bits cover the sqrt(2) reach and the cordic gain
	localparam int XY_W   = DIFF_W + CORDIC_STEPS + 2;
	// sign, nine integer bits (start angle plus table sum stays below 512)
	localparam int Z_W    = ANG_Q + 10;
	localparam int TH_W   = Z_W + 1;
	localparam int RND_SH = ANG_Q - ANGLE_FRAC_BITS;
	localparam int RND_W  = TH_W - RND_SH;

	// difference, pre-rotation, then one register per cordic step
	localparam int LANE_STAGES = CORDIC_STEPS + 2;
	// wrap and rounding stages after the lanes
	localparam int PIPE_STAGES = LANE_STAGES + 2;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic signed [DIFF_W-1:0]     diff_t;
	typedef logic signed [XY_W-1:0]       xy_t;
	typedef logic signed [Z_W-1:0]        z_t;
	typedef logic signed [TH_W-1:0]       th_t;
	typedef logic signed [RND_W-1:0]      rnd_t;
	typedef logic signed [ANGLE_W-1:0]    angle_t;

	localparam z_t  DEG180_Z  = Z_W'(180 << ANG_Q);
	localparam th_t DEG180_TH = TH_W'(180 << ANG_Q);
	localparam th_t DEG360_TH = TH_W'(360 << ANG_Q);

	// round(atan(2^-i) * 180/pi * 2^16)
	function automatic z_t atan_q16(input int idx);
		z_t v;
		case (idx)
			0:       v = Z_W'(2949120);
			1:       v = Z_W'(1740967);
			2:       v = Z_W'(919879);
			3:       v = Z_W'(466945);
			4:       v = Z_W'(234379);
			5:       v = Z_W'(117304);
			6:       v = Z_W'(58666);
			7:       v = Z_W'(29335);
			8:       v = Z_W'(14668);
			9:       v = Z_W'(7334);
			10:      v = Z_W'(3667);
			11:      v = Z_W'(1833);
			12:      v = Z_W'(917);
			13:      v = Z_W'(458);
			14:      v = Z_W'(229);
			15:      v = Z_W'(115);
			16:      v = Z_W'(57);
			17:      v = Z_W'(29);
			18:      v = Z_W'(14);
			19:      v = Z_W'(7);
			20:      v = Z_W'(4);
			21:      v = Z_W'(2);
			22:      v = Z_W'(1);
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

@@ rtl/abr_if.sv @@
// valid/ready channels of the ray angle unit: ray triple in, angle out
interface abr_ray_if import abr_pkg::*; ();
	logic   valid;
	logic   ready;
	coord_t p1_x;
	coord_t p1_y;
	coord_t p2_x;
	coord_t p2_y;
	coord_t cross_x;
	coord_t cross_y;

	modport source(output valid, p1_x, p1_y, p2_x, p2_y, cross_x, cross_y, input ready);
	modport sink(input valid, p1_x, p1_y, p2_x, p2_y, cross_x, cross_y, output ready);
endinterface

interface abr_angle_if import abr_pkg::*; ();
	logic   valid;
	logic   ready;
	angle_t angle_deg;

	modport source(output valid, angle_deg, input ready);
	modport sink(input valid, angle_deg, output ready);
endinterface

@@ rtl/abr_lane.sv @@
// one ray lane: difference vector and pipelined vectoring cordic angle
module abr_lane import abr_pkg::*; (
	input  logic   clk,
	input  logic   en,
	input  coord_t end_x,
	input  coord_t end_y,
	input  coord_t vtx_x,
	input  coord_t vtx_y,
	output z_t     ang
);

	// abscissa is the row difference, ordinate the column difference
	diff_t ax_s1;
	diff_t ay_s1;

	xy_t  x_start;
	xy_t  y_start;
	xy_t  x_scaled;
	xy_t  y_scaled;
	z_t   z_start;
	logic zero_start;

	// index k holds the vector after k steps (index 0 is stage 2)
	xy_t  x_sn    [CORDIC_STEPS+1];
	xy_t  y_sn    [CORDIC_STEPS+1];
	z_t   z_sn    [CORDIC_STEPS+1];
	logic zero_sn [CORDIC_STEPS+1];

	always_ff @(posedge clk) begin
		if (en) begin
			ax_s1 <= {end_y[COORD_BITS-1], end_y} - {vtx_y[COORD_BITS-1], vtx_y};
			ay_s1 <= {end_x[COORD_BITS-1], end_x} - {vtx_x[COORD_BITS-1], vtx_x};
		end
	end

	// guard bits below, then turn a left-half vector by 180 degrees
	always_comb begin
		x_scaled   = {{(XY_W-DIFF_W-CORDIC_STEPS){ax_s1[DIFF_W-1]}}, ax_s1,
			{CORDIC_STEPS{1'b0}}};
		y_scaled   = {{(XY_W-DIFF_W-CORDIC_STEPS){ay_s1[DIFF_W-1]}}, ay_s1,
			{CORDIC_STEPS{1'b0}}};
		zero_start = (ax_s1 == '0) && (ay_s1 == '0);
		if (ax_s1[DIFF_W-1]) begin
			x_start = -x_scaled;
			y_start = -y_scaled;
			z_start = ay_s1[DIFF_W-1] ? -DEG180_Z : DEG180_Z;
		end else begin
			x_start = x_scaled;
			y_start = y_scaled;
			z_start = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_sn[0]    <= x_start;
			y_sn[0]    <= y_start;
			z_sn[0]    <= z_start;
			zero_sn[0] <= zero_start;
		end
	end

	for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_step
		xy_t xs;
		xy_t ys;

		assign xs = x_sn[g] >>> g;
		assign ys = y_sn[g] >>> g;

		always_ff @(posedge clk) begin
			if (en) begin
				if (!y_sn[g][XY_W-1]) begin
					x_sn[g+1] <= x_sn[g] + ys;
					y_sn[g+1] <= y_sn[g] - xs;
					z_sn[g+1] <= z_sn[g] + atan_q16(g);
				end else begin
					x_sn[g+1] <= x_sn[g] - ys;
					y_sn[g+1] <= y_sn[g] + xs;
					z_sn[g+1] <= z_sn[g] - atan_q16(g);
				end
				zero_sn[g+1] <= zero_sn[g];
			end
		end
	end

	// a zero vector has angle 0
	assign ang = zero_sn[CORDIC_STEPS] ? '0 : z_sn[CORDIC_STEPS];

endmodule

@@ rtl/abr_merge.sv @@
// merge of the two lane angles: difference, wrap, round and saturate
module abr_merge import abr_pkg::*; (
	input  logic   clk,
	input  logic   en,
	input  z_t     ang1,
	input  z_t     ang2,
	output angle_t angle_deg
);

	localparam th_t  RND_HALF = TH_W'(1 << (RND_SH - 1));
	localparam rnd_t OUT_MAX  = RND_W'((1 << (ANGLE_W - 1)) - 1);
	localparam rnd_t OUT_MIN  = -RND_W'(1 << (ANGLE_W - 1));

	th_t    diff;
	th_t    wrapped;
	th_t    th_s1;
	th_t    biased;
	rnd_t   rnd;
	angle_t sat;
	angle_t angle_s2;

	always_comb begin
		diff = {ang1[Z_W-1], ang1} - {ang2[Z_W-1], ang2};
		if (diff > DEG180_TH) begin
			wrapped = diff - DEG360_TH;
		end else if (diff < -DEG180_TH) begin
			wrapped = diff + DEG360_TH;
		end else begin
			wrapped = diff;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			th_s1 <= wrapped;
		end
	end

	// round half up by the arithmetic shift, then clamp to the port range
	always_comb begin
		biased = th_s1 + RND_HALF;
		rnd    = biased[TH_W-1:RND_SH];
		if (rnd > OUT_MAX) begin
			sat = OUT_MAX[ANGLE_W-1:0];
		end else if (rnd < OUT_MIN) begin
			sat = OUT_MIN[ANGLE_W-1:0];
		end else begin
			sat = rnd[ANGLE_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			angle_s2 <= sat;
		end
	end

	assign angle_deg = angle_s2;

endmodule

@@ rtl/angle_between_two_rays_unit.sv @@
// top level of the ray angle unit: two cordic lanes, merge and output skid
//
//  channel  | modport | beat contents
//  ---------+---------+-----------------------------------------------
//  rays     | sink    | p1_x, p1_y, p2_x, p2_y, cross_x, cross_y
//  angle    | source  | angle_deg, signed degrees, ANGLE_FRAC_BITS frac bits
//
// one beat in and one beat out per cycle when the output is not stalled
// the pipeline is the one-register-per-step cordic in each lane plus
// difference, pre-rotation, wrap and rounding stages
// arst_n clears the stage valid bits and the skid; data registers are not reset
// a stall on angle parks the tail beat in the skid, then the whole pipeline
// holds until the skid drains
module angle_between_two_rays_unit import abr_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	abr_ray_if.sink   rays,
	abr_angle_if.source angle
);

	// pipeline advance: the skid is empty, so the tail beat has a place to go
	logic                   en;
	logic [PIPE_STAGES-1:0] valid_q;
	logic                   tail_valid;
	angle_t                 tail_angle;
	logic                   skid_valid_q;
	angle_t                 skid_angle_q;

	z_t ang1;
	z_t ang2;

	assign en         = !skid_valid_q;
	assign rays.ready = en;
	assign tail_valid = valid_q[PIPE_STAGES-1];

	// stage valid bits move together with the lane data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (en) begin
			valid_q <= {valid_q[PIPE_STAGES-2:0], rays.valid};
		end
	end

	// lane 1 measures the first ray, lane 2 the second
	abr_lane u_lane1 (
		.clk   (clk),
		.en    (en),
		.end_x (rays.p1_x),
		.end_y (rays.p1_y),
		.vtx_x (rays.cross_x),
		.vtx_y (rays.cross_y),
		.ang   (ang1)
	);

	abr_lane u_lane2 (
		.clk   (clk),
		.en    (en),
		.end_x (rays.p2_x),
		.end_y (rays.p2_y),
		.vtx_x (rays.cross_x),
		.vtx_y (rays.cross_y),
		.ang   (ang2)
	);

	abr_merge u_merge (
		.clk       (clk),
		.en        (en),
		.ang1      (ang1),
		.ang2      (ang2),
		.angle_deg (tail_angle)
	);

	// skid: catches the tail beat when the consumer is not ready
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (angle.ready) begin
				skid_valid_q <= 1'b0;
			end
		end else if (tail_valid && !angle.ready) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!skid_valid_q) begin
			skid_angle_q <= tail_angle;
		end
	end

	// the skid beat is older than the held tail, so it goes first
	assign angle.valid     = skid_valid_q || tail_valid;
	assign angle.angle_deg = skid_valid_q ? skid_angle_q : tail_angle;

`ifndef SYNTH
	// the skid only fills from a stalled output
	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_valid_q) |-> $past(tail_valid && !angle.ready))
		else $error("skid filled without an output stall");

	// a parked beat stays put until taken
	a_skid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q && !angle.ready |=> skid_valid_q && $stable(skid_angle_q))
		else $error("skid beat lost or changed during stall");

	// an accepted beat enters the first stage
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		rays.valid && rays.ready |=> valid_q[0])
		else $error("accepted beat missing from first stage");

	// while the skid drains the tail beat is held
	a_tail_hold: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q && tail_valid |=> tail_valid && $stable(tail_angle))
		else $error("tail beat moved while skid full");
`endif

endmodule

@@ bench/abr_angle_checker.sv @@
// checker of the ray angle unit: predicts every angle beat and compares it
`timescale 1ns / 100ps
module abr_angle_checker import abr_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	abr_ray_if    rays,
	abr_angle_if  angle,
	output int    mismatches,
	output int    outstanding
);

	localparam int STEPS      = 16;
	localparam int FRAC       = 7;
	localparam int HEAD_Q     = 16;
	localparam int ATAN_LEN   = 24;
	localparam longint HALF_TURN = longint'(180) << HEAD_Q;
	localparam longint FULL_TURN = longint'(360) << HEAD_Q;

	// atan(2^-i) in degrees, 16 fractional bits
	localparam longint ATAN_STEP [0:ATAN_LEN-1] = '{
		2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
		14668, 7334, 3667, 1833, 917, 458, 229, 115,
		57, 29, 14, 7, 4, 2, 1, 0
	};

	angle_t expected_angles[$];
	angle_t want;
	int     angle_beats;

	initial mismatches = 0;

	task automatic report_mismatch(input string msg);
		$display("%0t angle check: %s", $time, msg);
		mismatches++;
	endtask

	// heading of a ray vector in degrees, abscissa ab and ordinate ord
	function automatic longint heading_q16(input longint ab, input longint ord);
		longint x, y, z, xs, ys;
		if (ab == 0 && ord == 0)
			return 0;
		x = ab * (longint'(1) << STEPS);
		y = ord * (longint'(1) << STEPS);
		z = 0;
		if (x < 0) begin
			z = (y >= 0) ? HALF_TURN : -HALF_TURN;
			x = -x;
			y = -y;
		end
		for (int i = 0; i < STEPS && i < ATAN_LEN; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y >= 0) begin
				x = x + ys;
				y = y - xs;
				z = z + ATAN_STEP[i];
			end else begin
				x = x - ys;
				y = y + xs;
				z = z - ATAN_STEP[i];
			end
		end
		return z;
	endfunction

	function automatic angle_t ray_angle_diff(input coord_t p1x, input coord_t p1y,
			input coord_t p2x, input coord_t p2y, input coord_t cx, input coord_t cy);
		longint ray1_heading, ray2_heading, diff, rounded;
		// row difference is the abscissa, column difference the ordinate
		ray1_heading = heading_q16(longint'(p1y) - longint'(cy), longint'(p1x) - longint'(cx));
		ray2_heading = heading_q16(longint'(p2y) - longint'(cy), longint'(p2x) - longint'(cx));
		diff = ray1_heading - ray2_heading;
		if (diff > HALF_TURN)
			diff -= FULL_TURN;
		if (diff < -HALF_TURN)
			diff += FULL_TURN;
		rounded = (diff + (longint'(1) << (HEAD_Q - FRAC - 1))) >>> (HEAD_Q - FRAC);
		if (rounded > 32767)
			rounded = 32767;
		if (rounded < -32768)
			rounded = -32768;
		return angle_t'(rounded);
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (angle.valid && angle.ready) begin
				if (expected_angles.size() == 0) begin
					report_mismatch($sformatf("beat %0d angle_deg %0d with nothing pending",
						angle_beats, angle.angle_deg));
				end else begin
					want = expected_angles.pop_front();
					if (angle.angle_deg !== want)
						report_mismatch($sformatf("beat %0d angle_deg %0d, want %0d",
							angle_beats, angle.angle_deg, want));
				end
				angle_beats++;
			end
			if (rays.valid && rays.ready)
				expected_angles.insert(expected_angles.size(),
					ray_angle_diff(rays.p1_x, rays.p1_y, rays.p2_x,
					rays.p2_y, rays.cross_x, rays.cross_y));
		end
		outstanding <= expected_angles.size();
	end

endmodule

@@ bench/angle_between_two_rays_unit_tb.sv @@
// testbench top of the ray angle unit: clock, reset, stimulus and verdict
`timescale 1ns / 100ps
module angle_between_two_rays_unit_tb import abr_pkg::*;;

	// settle time after the final drain, so that it covers any straggler
	localparam int SETTLE_CYCLES = 40;
	localparam int RANDOM_RAYS   = 550;
	localparam int HOLD_CYCLES   = 150;

	logic clk;
	logic arst_n;
	// asks the receiver for its one long hold-off
	logic hold_req;
	// both sides run flat out while this is high
	logic burst;
	int   mismatches;
	int   outstanding;

	abr_ray_if   ray_bus();
	abr_angle_if angle_bus();

	angle_between_two_rays_unit DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.rays   (ray_bus),
		.angle  (angle_bus)
	);

	// watches both channels, keeps the expected angles and counts mismatches
	abr_angle_checker angle_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.rays        (ray_bus),
		.angle       (angle_bus),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// offer one ray triple and hold it until the block takes the beat
	task automatic push_ray(input coord_t p1x, input coord_t p1y, input coord_t p2x,
			input coord_t p2y, input coord_t cx, input coord_t cy);
		ray_bus.valid   <= 1'b1;
		ray_bus.p1_x    <= p1x;
		ray_bus.p1_y    <= p1y;
		ray_bus.p2_x    <= p2x;
		ray_bus.p2_y    <= p2y;
		ray_bus.cross_x <= cx;
		ray_bus.cross_y <= cy;
		do @(posedge clk); while (!ray_bus.ready);
	endtask

	// stop offering and wait until every predicted angle has come out
	// the first edge lets the checker count the last accepted beat
	task automatic drain_angles;
		ray_bus.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	// receiver side: random back-pressure, one long hold-off, steady in bursts
	initial begin
		int hold_left;
		bit hold_taken;
		hold_left  = 0;
		hold_taken = 1'b0;
		angle_bus.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req && !hold_taken) begin
				hold_taken = 1'b1;
				hold_left  = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				// long enough to fill every stage and the skid
				hold_left--;
				angle_bus.ready <= 1'b0;
			end else if (burst) begin
				angle_bus.ready <= 1'b1;
			end else begin
				angle_bus.ready <= ($urandom_range(99) >= 24);
			end
		end
	end

	// sender side and verdict
	initial begin
		int     kind;
		int     span;
		int     o1x, o1y, o2x, o2y;
		bit     steady;
		coord_t vx, vy;

		arst_n          = 1'b0;
		hold_req        = 1'b0;
		burst           = 1'b0;
		ray_bus.valid   = 1'b0;
		ray_bus.p1_x    = '0;
		ray_bus.p1_y    = '0;
		ray_bus.p2_x    = '0;
		ray_bus.p2_y    = '0;
		ray_bus.cross_x = '0;
		ray_bus.cross_y = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rays, arguments are p1, p2, vertex
		// both vectors zero, then only the first one zero
		push_ray(0, 0, 0, 0, 0, 0);
		push_ray(5, 5, 5, 9, 5, 5);
		// largest differences either way against a zero second ray
		push_ray(32767, 32767, -32768, -32768, -32768, -32768);
		push_ray(-32768, -32768, 32767, 32767, 32767, 32767);
		// negative abscissa on the axis: turns to +180, close to the edge
		push_ray(0, -100, 0, 100, 0, 0);
		push_ray(0, 100, 0, -100, 0, 0);
		// negative abscissa either side of the axis: difference wraps both ways
		push_ray(-1, -50, 1, -50, 0, 0);
		push_ray(1, -50, -1, -50, 0, 0);
		// opposite quarter turns: difference sits on +180 and -180
		push_ray(100, 0, -100, 0, 0, 0);
		push_ray(-100, 0, 100, 0, 0, 0);
		// short vectors near the vertex
		push_ray(1, 0, 0, 1, 0, 0);
		push_ray(-1, -1, 1, 1, 0, 0);
		push_ray(3, 4, 4, 3, 0, 0);
		// opposite corners of the coordinate range
		push_ray(32767, -32768, -32768, 32767, 0, 0);
		push_ray(-32768, 32767, 32767, -32768, -1, -1);
		// extreme and all-ones values on every field, alternating bit patterns, then one mixed triple
		push_ray(32767, 32767, 32767, 32767, 32767, 32767);
		push_ray(-32768, -32768, -32768, -32768, -32768, -32768);
		push_ray(-1, -1, -1, -1, -1, -1);
		push_ray(21845, -21846, -21846, 21845, 21845, 21845);
		push_ray(-21846, 21845, 21845, -21846, -21846, 21845);
		push_ray(12, 7, -3, 40, -20, 9);
		drain_angles();

		for (int n = 0; n < RANDOM_RAYS; n++) begin
			if (n == 120)
				hold_req <= 1'b1;
			// sender pause: let the whole pipeline empty
			if (n == 275)
				drain_angles();
			steady = (n >= 350 && n < 450);
			burst <= steady;
			while (!steady && $urandom_range(99) < 24) begin
				ray_bus.valid <= 1'b0;
				@(posedge clk);
			end

			vx   = coord_t'($urandom);
			vy   = coord_t'($urandom);
			// mostly short rays around the vertex, now and then any length
			span = ($urandom_range(7) == 0) ? 32767 : 300;
			o1x  = int'($urandom_range(2 * span)) - span;
			o1y  = int'($urandom_range(2 * span)) - span;
			o2x  = int'($urandom_range(2 * span)) - span;
			o2y  = int'($urandom_range(2 * span)) - span;
			kind = $urandom_range(9);
			case (kind)
				0, 1, 2: begin
					push_ray(coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
						coord_t'($urandom), coord_t'($urandom), coord_t'($urandom));
				end
				3: begin
					// first ray on the column axis, second on the row axis
					push_ray(vx, coord_t'(vy + o1y), coord_t'(vx + o2x), vy, vx, vy);
				end
				4: begin
					push_ray(vx, vy, coord_t'(vx + o2x), coord_t'(vy + o2y), vx, vy);
				end
				5: begin
					push_ray(coord_t'(vx + o1x), coord_t'(vy + o1y), vx, vy, vx, vy);
				end
				default: begin
					push_ray(coord_t'(vx + o1x), coord_t'(vy + o1y), coord_t'(vx + o2x),
						coord_t'(vy + o2y), vx, vy);
				end
			endcase
		end
		burst <= 1'b0;
		drain_angles();
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// watchdog, far beyond the slowest correct run
	initial begin
		#2000000;
		$display("Mismatches found");
		$finish;
	end

endmodule

@@ angle_between_two_rays_unit.f @@
rtl/abr_pkg.sv
rtl/abr_if.sv
rtl/abr_lane.sv
rtl/abr_merge.sv
rtl/angle_between_two_rays_unit.sv
bench/abr_angle_checker.sv
bench/angle_between_two_rays_unit_tb.sv
